// File: rtl/aescbc_pkg.sv
package aescbc_pkg;

  // Configuration register indexes (byte address is eight times the index).
  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_KLEN = 3'd4;
  localparam logic [2:0] REG_IVHI = 3'd5;
  localparam logic [2:0] REG_IVLO = 3'd6;

  // Key length codes.
  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;
  localparam logic [1:0] KLEN_256 = 2'd2;

  localparam int RK_DEPTH = 15;

  typedef struct packed {
    logic        func;
    logic        first_block;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_t;

  typedef struct packed {
    logic [63:0] out_hi;
    logic [63:0] out_lo;
  } out_t;

  // One classified job waiting for the round engine.
  typedef struct packed {
    logic         dec;
    logic         use_iv;
    logic [127:0] blk;
  } job_t;

  typedef logic [255:0][7:0] tbl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // The inverse table is worked out at elaboration from the forward one.
  function automatic tbl_t build_inv();
    tbl_t t;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam tbl_t INV_SBOX = build_inv();

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [3:0] nr_of(input logic [1:0] klen);
    if (klen == KLEN_128) begin
      return 4'd10;
    end else if (klen == KLEN_192) begin
      return 4'd12;
    end
    return 4'd14;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte k of a block sits at bits 127-8k down to 120-8k.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) begin
      t[127 - 8 * i -: 8] = SBOX[s[127 - 8 * ((i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)) -: 8]];
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) begin
      t[127 - 8 * ((i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)) -: 8] =
        INV_SBOX[s[127 - 8 * i -: 8]];
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  // Multiplies by 9, 11, 13 and 14 built from doublings.
  function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x1, x2, x3;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j] = s[127 - 32 * c - 8 * j -: 8];
        x1 = xtime(a[j]);
        x2 = xtime(x1);
        x3 = xtime(x2);
        m9[j] = x3 ^ a[j];
        m11[j] = x3 ^ x1 ^ a[j];
        m13[j] = x3 ^ x2 ^ a[j];
        m14[j] = x3 ^ x2 ^ x1;
      end
      t[127 - 32 * c -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      t[119 - 32 * c -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      t[111 - 32 * c -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      t[103 - 32 * c -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    return t;
  endfunction

endpackage

// File: rtl/aes_cbc_cipher.sv
// Channel   Ports                              Carries
// input     in_valid, in_stall, in_data        one 128-bit block, func, first_block
// result    out_valid, out_stall, out_data     one 128-bit result block
// config    psel, penable, pwrite, paddr, ...  key, key length, IV (64-bit APB)
//
// A block passes through the round engine one round per cycle on a single shared
// round unit; its last round waits while a stalled result still fills the output.
// A two-entry queue takes new blocks while the engine works and a result waits.
// After reset and after each key or key length write, key expansion runs,
// and in_stall stays high until it is done.
// Reset is synchronous and active low; the chaining value resets to zero.
module aes_cbc_cipher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  aescbc_pkg::in_t    in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output aescbc_pkg::out_t   out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import aescbc_pkg::*;

  logic [63:0]  key0_r, key1_r, key2_r, key3_r, ivhi_r, ivlo_r;
  logic [1:0]   klen_r;
  logic         wr_en, key_start, key_busy;
  logic [2:0]   reg_idx;
  logic         q_valid, q_pop;
  job_t         q_data;
  logic [3:0]   rk_idx;
  logic [127:0] rk;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[5:3];
  assign wr_en     = psel && penable && pwrite;
  assign key_start = wr_en && (reg_idx == REG_KEY0 || reg_idx == REG_KEY1 ||
                               reg_idx == REG_KEY2 || reg_idx == REG_KEY3 ||
                               reg_idx == REG_KLEN);

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
      klen_r <= KLEN_128;
      ivhi_r <= '0;
      ivlo_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KEY0: key0_r <= pwdata;
        REG_KEY1: key1_r <= pwdata;
        REG_KEY2: key2_r <= pwdata;
        REG_KEY3: key3_r <= pwdata;
        REG_KLEN: klen_r <= pwdata[1:0];
        REG_IVHI: ivhi_r <= pwdata;
        REG_IVLO: ivlo_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_KEY0: prdata = key0_r;
      REG_KEY1: prdata = key1_r;
      REG_KEY2: prdata = key2_r;
      REG_KEY3: prdata = key3_r;
      REG_KLEN: prdata = {62'd0, klen_r};
      REG_IVHI: prdata = ivhi_r;
      REG_IVLO: prdata = ivlo_r;
      default:  prdata = '0;
    endcase
  end

  aescbc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .key_busy (key_busy),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  aescbc_keyexp u_keyexp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (key_start),
    .key_w0 (key0_r),
    .key_w1 (key1_r),
    .key_w2 (key2_r),
    .key_w3 (key3_r),
    .klen   (klen_r),
    .busy   (key_busy),
    .rk_idx (rk_idx),
    .rk     (rk)
  );

  aescbc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .klen      (klen_r),
    .iv_hi     (ivhi_r),
    .iv_lo     (ivlo_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .rk_idx    (rk_idx),
    .rk        (rk),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/aescbc_front.sv
module aescbc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aescbc_pkg::in_t     in_data,
  input  logic                key_busy,
  output logic                q_valid,
  output aescbc_pkg::job_t    q_data,
  input  logic                q_pop
);
  import aescbc_pkg::*;

  job_t       q_mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  // Hold inputs off while the queue is full or round keys are being rebuilt.
  assign in_stall = (cnt_r == 2'd2) || key_busy;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_mem[rd_ptr_r];

  // Classify the transaction and queue it.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= '{dec: in_data.func, use_iv: in_data.first_block,
                           blk: {in_data.block_hi, in_data.block_lo}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (q_pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0) else $error("queue popped while empty");

endmodule

// File: rtl/aescbc_keyexp.sv
module aescbc_keyexp (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  key_w0,
  input  logic [63:0]  key_w1,
  input  logic [63:0]  key_w2,
  input  logic [63:0]  key_w3,
  input  logic [1:0]   klen,
  output logic         busy,
  input  logic [3:0]   rk_idx,
  output logic [127:0] rk
);
  import aescbc_pkg::*;

  logic [127:0] rk_r [RK_DEPTH];
  logic [31:0]  win_r [8];
  logic [31:0]  kw [8];
  logic         pend_r, run_r;
  logic [5:0]   i_r;
  logic [2:0]   mod_r;
  logic [7:0]   rcon_r;
  logic [3:0]   nk;
  logic [5:0]   total;
  logic [31:0]  oldest, t, word;
  logic         is_last;

  assign busy = pend_r || run_r;
  assign rk   = rk_r[rk_idx];

  // Window of the last nk words; the oldest one sits at 8 - nk.
  always_comb begin
    nk    = nr_of(klen) - 4'd6;
    total = {nr_of(klen), 2'b00} + 6'd4;
    kw    = '{key_w0[63:32], key_w0[31:0], key_w1[63:32], key_w1[31:0],
              key_w2[63:32], key_w2[31:0], key_w3[63:32], key_w3[31:0]};
    case (nk)
      4'd4:    oldest = win_r[4];
      4'd6:    oldest = win_r[2];
      default: oldest = win_r[0];
    endcase
    t = win_r[7];
    if (mod_r == 3'd0) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {rcon_r, 24'd0};
    end else if (nk == 4'd8 && mod_r == 3'd4) begin
      t = sub_word(t);
    end
    word    = ({2'b00, i_r} < {4'd0, nk}) ? oldest : (oldest ^ t);
    is_last = (i_r == total - 6'd1);
  end

  // One expanded word per cycle; the key words themselves rotate through first.
  always_ff @(posedge clk) begin
    if (pend_r) begin
      for (int j = 0; j < 8; j++) begin
        if (j >= 8 - int'(nk)) begin
          win_r[j] <= kw[j - 8 + int'(nk)];
        end
      end
    end else if (run_r) begin
      rk_r[i_r[5:2]][{~i_r[1:0], 5'd0} +: 32] <= word;
      for (int j = 0; j < 7; j++) begin
        win_r[j] <= win_r[j + 1];
      end
      win_r[7] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b1;
      run_r  <= 1'b0;
      i_r    <= 6'd0;
      mod_r  <= 3'd0;
      rcon_r <= 8'h01;
    end else if (start) begin
      pend_r <= 1'b1;
      run_r  <= 1'b0;
    end else if (pend_r) begin
      pend_r <= 1'b0;
      run_r  <= 1'b1;
      i_r    <= 6'd0;
      mod_r  <= 3'd0;
      rcon_r <= 8'h01;
    end else if (run_r) begin
      i_r   <= i_r + 6'd1;
      mod_r <= ({1'b0, mod_r} == nk - 4'd1) ? 3'd0 : mod_r + 3'd1;
      if (({2'b00, i_r} >= {4'd0, nk}) && mod_r == 3'd0) begin
        rcon_r <= xtime(rcon_r);
      end
      if (is_last) begin
        run_r <= 1'b0;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> i_r < total) else $error("key word index past schedule");

  a_pend_then_run: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && !start |=> run_r && i_r == 6'd0) else $error("expansion did not start");

endmodule

// File: rtl/aescbc_core.sv
module aescbc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          klen,
  input  logic [63:0]         iv_hi,
  input  logic [63:0]         iv_lo,
  input  logic                q_valid,
  input  aescbc_pkg::job_t    q_data,
  output logic                q_pop,
  output logic [3:0]          rk_idx,
  input  logic [127:0]        rk,
  output logic                out_valid,
  input  logic                out_stall,
  output aescbc_pkg::out_t    out_data
);
  import aescbc_pkg::*;

  logic         busy_r, dec_r, outv_r;
  logic [3:0]   rnd_r;
  logic [127:0] st_r, xcv_r, blk_r, cv_r, out_r;
  logic [3:0]   nr;
  logic [127:0] cv_sel, enc_s, dec_s, nxt_s, res;
  logic         last, out_free, fin;

  assign out_valid = outv_r;
  assign out_data  = '{out_hi: out_r[127:64], out_lo: out_r[63:0]};
  assign out_free  = !outv_r || !out_stall;
  assign q_pop     = !busy_r && q_valid;

  // One AES round per cycle on the shared round unit; the last round waits while a stalled result fills the output.
  always_comb begin
    nr     = nr_of(klen);
    cv_sel = q_data.use_iv ? {iv_hi, iv_lo} : cv_r;
    if (!busy_r) begin
      rk_idx = q_data.dec ? nr : 4'd0;
    end else begin
      rk_idx = dec_r ? rnd_r - 4'd1 : rnd_r;
    end
    last  = dec_r ? (rnd_r == 4'd1) : (rnd_r == nr);
    enc_s = sub_shift(st_r);
    if (!last) begin
      enc_s = mix_cols(enc_s);
    end
    enc_s = enc_s ^ rk;
    dec_s = inv_shift_sub(st_r) ^ rk;
    if (!last) begin
      dec_s = inv_mix_cols(dec_s);
    end
    nxt_s = dec_r ? dec_s : enc_s;
    res   = dec_r ? (nxt_s ^ xcv_r) : nxt_s;
    fin   = busy_r && last && out_free;
  end

  // Data path registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      st_r  <= q_data.dec ? (q_data.blk ^ rk) : (q_data.blk ^ cv_sel ^ rk);
      xcv_r <= cv_sel;
      blk_r <= q_data.blk;
    end else if (busy_r && !last) begin
      st_r <= nxt_s;
    end
    if (fin) begin
      out_r <= res;
    end
  end

  // Sequencing, chaining value and output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dec_r  <= 1'b0;
      rnd_r  <= 4'd0;
      outv_r <= 1'b0;
      cv_r   <= '0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        dec_r  <= q_data.dec;
        rnd_r  <= q_data.dec ? nr : 4'd1;
      end else if (busy_r && !last) begin
        rnd_r <= dec_r ? rnd_r - 4'd1 : rnd_r + 4'd1;
      end
      if (fin) begin
        busy_r <= 1'b0;
        outv_r <= 1'b1;
        cv_r   <= dec_r ? blk_r : res;
      end else if (!out_stall) begin
        outv_r <= 1'b0;
      end
    end
  end

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rnd_r >= 4'd1 && rnd_r <= nr) else $error("round counter out of range");

  a_fin_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> outv_r && !busy_r) else $error("finished block not presented");

endmodule
